>>> rtl/bst_pkg.sv
// Package with the types and constants shared by the bounded set table.
`timescale 1ns / 1ps

package bst_pkg;

	// Widths of the element data and of the fill count.
	localparam int DATA_W = 32;
	localparam int FILL_W = 7;

	// Action codes.
	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Reset value of the capacity register.
	localparam logic [FILL_W-1:0] CAPACITY_RESET = 7'd64;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_APPEND
	} state_t;

endpackage

>>> rtl/bounded_set_table.sv
// Set of distinct signed 32-bit values packed in a table with one read and one write port.
// A failed add (full) or a remove on an empty set is reported in the cycle after start;
// otherwise the search reads and then compares each entry in turn, a remove then shifts each
// later entry down with a read and a write, and the result strobe follows the last step.
// Throughput: one operation at a time; once raised, busy stays high until the result strobe.
// The pace is set by the table's one read port, shared by the search and the shift pass.
// Reset clears the fill count and sets capacity to 64; table contents are not cleared.
`timescale 1ns / 1ps

module bounded_set_table #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          capacity_we,
	input  logic [bst_pkg::FILL_W-1:0]    capacity_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic signed [bst_pkg::DATA_W-1:0] value,
	output logic                          done,
	output logic                          ok,
	output logic [bst_pkg::FILL_W-1:0]    size
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Largest fill the counter can reach, bounded by the table depth.
	localparam logic [bst_pkg::FILL_W-1:0] DEPTH_CAP =
		(DEPTH > 127) ? 7'd127 : bst_pkg::FILL_W'(DEPTH);

	bst_pkg::state_t state_q, state_d;

	logic [bst_pkg::FILL_W-1:0] capacity_q;
	logic [bst_pkg::FILL_W-1:0] fill_q, fill_d;
	logic [bst_pkg::FILL_W-1:0] idx_q;
	logic [bst_pkg::FILL_W-1:0] idx_nxt;
	logic [bst_pkg::FILL_W-1:0] limit;
	logic                       act_q;
	logic [bst_pkg::DATA_W-1:0] value_q;
	logic                       accept;

	// Table storage with one write and one registered read port.
	logic [bst_pkg::DATA_W-1:0] mem [DEPTH];
	logic [bst_pkg::DATA_W-1:0] rdata_q;
	logic                       mem_re, mem_we;
	logic [AW-1:0]              mem_raddr, mem_waddr;
	logic [bst_pkg::DATA_W-1:0] mem_wdata;

	// Control strobes from the sequencer.
	logic idx_clr, idx_inc, fill_inc, fill_dec, finish, finish_ok;
	logic done_q, ok_q;
	logic [bst_pkg::FILL_W-1:0] size_q;

	// Limit is the lower of capacity and depth.
	assign limit   = (capacity_q < DEPTH_CAP) ? capacity_q : DEPTH_CAP;
	assign idx_nxt = bst_pkg::FILL_W'(idx_q + 7'd1);
	assign busy    = (state_q != bst_pkg::ST_IDLE);
	assign accept  = start && !busy;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bst_pkg::ST_IDLE: begin
				if (accept) begin
					if (action == bst_pkg::ACT_ADD) begin
						if (fill_q < limit) begin
							state_d = bst_pkg::ST_SRCH_RD;
						end
					end else if (fill_q != '0) begin
						state_d = bst_pkg::ST_SRCH_RD;
					end
				end
			end
			bst_pkg::ST_SRCH_RD: begin
				if (idx_q == fill_q) begin
					state_d = (act_q == bst_pkg::ACT_ADD) ? bst_pkg::ST_APPEND
						: bst_pkg::ST_IDLE;
				end else begin
					state_d = bst_pkg::ST_SRCH_CMP;
				end
			end
			bst_pkg::ST_SRCH_CMP: begin
				if (rdata_q == value_q) begin
					state_d = (act_q == bst_pkg::ACT_ADD) ? bst_pkg::ST_IDLE
						: bst_pkg::ST_SHIFT_RD;
				end else begin
					state_d = bst_pkg::ST_SRCH_RD;
				end
			end
			bst_pkg::ST_SHIFT_RD: begin
				state_d = (idx_nxt == fill_q) ? bst_pkg::ST_IDLE : bst_pkg::ST_SHIFT_WR;
			end
			bst_pkg::ST_SHIFT_WR: begin
				state_d = bst_pkg::ST_SHIFT_RD;
			end
			bst_pkg::ST_APPEND: begin
				state_d = bst_pkg::ST_IDLE;
			end
			default: begin
				state_d = bst_pkg::ST_IDLE;
			end
		endcase
	end

	// Output and datapath control of the sequencer.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = AW'(idx_q);
		mem_we    = 1'b0;
		mem_waddr = AW'(idx_q);
		mem_wdata = rdata_q;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		fill_inc  = 1'b0;
		fill_dec  = 1'b0;
		finish    = 1'b0;
		finish_ok = 1'b0;
		unique case (state_q)
			bst_pkg::ST_IDLE: begin
				if (accept) begin
					idx_clr = 1'b1;
					if (action == bst_pkg::ACT_ADD) begin
						finish = !(fill_q < limit);
					end else begin
						finish = (fill_q == '0);
					end
				end
			end
			bst_pkg::ST_SRCH_RD: begin
				if (idx_q == fill_q) begin
					// Not found: a remove fails here, an add goes on to append.
					finish = (act_q == bst_pkg::ACT_REMOVE);
				end else begin
					mem_re = 1'b1;
				end
			end
			bst_pkg::ST_SRCH_CMP: begin
				if (rdata_q == value_q) begin
					if (act_q == bst_pkg::ACT_ADD) begin
						finish    = 1'b1;
						finish_ok = 1'b1;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			bst_pkg::ST_SHIFT_RD: begin
				if (idx_nxt == fill_q) begin
					fill_dec  = 1'b1;
					finish    = 1'b1;
					finish_ok = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(idx_nxt);
				end
			end
			bst_pkg::ST_SHIFT_WR: begin
				mem_we  = 1'b1;
				idx_inc = 1'b1;
			end
			bst_pkg::ST_APPEND: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(fill_q);
				mem_wdata = value_q;
				fill_inc  = 1'b1;
				finish    = 1'b1;
				finish_ok = 1'b1;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	// New fill count after this cycle.
	always_comb begin
		fill_d = fill_q;
		if (fill_inc) begin
			fill_d = bst_pkg::FILL_W'(fill_q + 7'd1);
		end else if (fill_dec) begin
			fill_d = bst_pkg::FILL_W'(fill_q - 7'd1);
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bst_pkg::ST_IDLE;
			capacity_q <= bst_pkg::CAPACITY_RESET;
			fill_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			done_q  <= finish;
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end
		end
	end

	// Operand, index and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			value_q <= value;
		end
		if (idx_clr) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_nxt;
		end
		if (finish) begin
			ok_q   <= finish_ok;
			size_q <= fill_d;
		end
	end

	// Table write and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign done = done_q;
	assign ok   = ok_q;
	assign size = size_q;

	// The fill count never passes the table depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_CAP)
		else $error("fill count beyond table depth");

	// The reported size is the fill count left by the transfer.
	a_size_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (size == fill_q))
		else $error("reported size differs from fill count");

	// The fill count changes only with a result.
	a_fill_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> done)
		else $error("fill count changed without a result");

	// An accepted operation keeps the block busy or reports at once.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted operation lost");

	// A result is raised only when the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result raised while busy");

endmodule

>>> tb/tb_bounded_set_table.sv
// Self-checking testbench for the bounded set table: a directed table, then random phases.
`timescale 1ns / 1ps

module tb_bounded_set_table;

	localparam int DEPTH     = 64;
	localparam int N_PHASES  = 12;
	localparam int PHASE_OPS = 127;
	localparam int POOL_SIZE = 96;
	localparam int N_ROWS    = 25;

	// Row kinds and checking modes of the directed table.
	localparam logic ROW_OP  = 1'b0;
	localparam logic ROW_CFG = 1'b1;
	localparam logic PRED    = 1'b0;
	localparam logic TYPED   = 1'b1;

	typedef struct packed {
		logic                       ok;
		logic [bst_pkg::FILL_W-1:0] size;
	} set_result_t;

	typedef struct packed {
		logic                       kind;
		logic [bst_pkg::FILL_W-1:0] cap;
		logic                       act;
		logic [bst_pkg::DATA_W-1:0] val;
		logic                       mode;
		logic                       exp_ok;
		logic [bst_pkg::FILL_W-1:0] exp_size;
	} stim_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              capacity_we;
	logic [bst_pkg::FILL_W-1:0]        capacity_wdata;
	logic                              start;
	logic                              busy;
	logic                              action;
	logic signed [bst_pkg::DATA_W-1:0] value;
	logic                              done;
	logic                              ok;
	logic [bst_pkg::FILL_W-1:0]        size;

	// Predicted contents of the set, in table order, and the capacity in force.
	logic [bst_pkg::DATA_W-1:0] members[$];
	logic [bst_pkg::FILL_W-1:0] capacity_now;
	set_result_t                pending_results[$];

	logic [bst_pkg::DATA_W-1:0] value_pool [POOL_SIZE];
	stim_row_t                  directed_rows [N_ROWS];
	int                         cap_plan [N_PHASES];
	int                         add_plan [N_PHASES];

	int mismatches;
	int ops_sent;
	int results_seen;
	int adds_ok;
	int adds_refused;
	int removes_ok;
	int removes_refused;
	int max_fill;
	int cap_writes;
	int burst_left;

	bounded_set_table #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata),
		.start(start),
		.busy(busy),
		.action(action),
		.value(value),
		.done(done),
		.ok(ok),
		.size(size)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Prints one line per mismatch and counts every one of them.
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Applies one add or remove to the predicted set and returns the outcome.
	function automatic set_result_t apply_set_op(input logic act,
			input logic [bst_pkg::DATA_W-1:0] v);
		set_result_t r;
		int          hit;
		int          lim;
		hit = -1;
		lim = (capacity_now < DEPTH) ? int'(capacity_now) : DEPTH;
		for (int i = 0; i < members.size(); i++) begin
			if (hit < 0 && members[i] == v) begin
				hit = i;
			end
		end
		if (act == bst_pkg::ACT_ADD) begin
			// A full set refuses the add even when the value is already held.
			if (members.size() >= lim) begin
				r.ok = 1'b0;
				adds_refused++;
			end else begin
				if (hit < 0) begin
					members.push_back(v);
				end
				r.ok = 1'b1;
				adds_ok++;
			end
		end else begin
			if (hit < 0) begin
				r.ok = 1'b0;
				removes_refused++;
			end else begin
				members.delete(hit);
				r.ok = 1'b1;
				removes_ok++;
			end
		end
		r.size = bst_pkg::FILL_W'(members.size());
		if (members.size() > max_fill) begin
			max_fill = members.size();
		end
		return r;
	endfunction

	// Ends a burst with a random gap, or carries on with start held high.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(25, 200)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(30, 60);
			end else begin
				burst_left = $urandom_range(0, 8);
			end
		end
	endtask

	// Presents one operation and waits for its transfer; the outcome is queued.
	task automatic issue_op(input logic act, input logic [bst_pkg::DATA_W-1:0] v,
			input logic mode, input logic t_ok, input logic [bst_pkg::FILL_W-1:0] t_size);
		set_result_t r;
		start  <= 1'b1;
		action <= act;
		value  <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = apply_set_op(act, v);
		if (mode == TYPED) begin
			r.ok   = t_ok;
			r.size = t_size;
		end
		pending_results.push_back(r);
		ops_sent++;
		pace_sender();
	endtask

	// Writes the capacity register once every outstanding result has come back.
	task automatic write_capacity(input logic [bst_pkg::FILL_W-1:0] c);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		capacity_we    <= 1'b1;
		capacity_wdata <= c;
		@(posedge clk);
		capacity_we  <= 1'b0;
		capacity_now = c;
		cap_writes++;
	endtask

	// Picks a value: often one already held, often one from a small pool, sometimes any.
	function automatic logic [bst_pkg::DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && members.size() > 0) begin
			return members[$urandom_range(0, members.size() - 1)];
		end else if (r < 88) begin
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		end
		return $urandom();
	endfunction

	// Each result strobe is one transfer, checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		set_result_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: ok=%0b size=%0d",
					ok, size));
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok) begin
					report_mismatch($sformatf("ok is %0b, predicted %0b", ok, want.ok));
				end
				if (size !== want.size) begin
					report_mismatch($sformatf("size is %0d, predicted %0d", size, want.size));
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then random phases at several capacities.
	initial begin
		int guard;
		arst_n         = 1'b0;
		capacity_we    = 1'b0;
		capacity_wdata = '0;
		start          = 1'b0;
		action         = bst_pkg::ACT_ADD;
		value          = '0;
		capacity_now   = bst_pkg::CAPACITY_RESET;
		mismatches      = 0;
		ops_sent        = 0;
		results_seen    = 0;
		adds_ok         = 0;
		adds_refused    = 0;
		removes_ok      = 0;
		removes_refused = 0;
		max_fill        = 0;
		cap_writes      = 0;
		burst_left      = 0;

		for (int i = 0; i < POOL_SIZE; i++) begin
			case (i % 3)
				0: value_pool[i] = $urandom();
				1: value_pool[i] = bst_pkg::DATA_W'($urandom_range(0, 40));
				default: value_pool[i] = -bst_pkg::DATA_W'($urandom_range(1, 40));
			endcase
		end

		directed_rows = '{
			// Empty set, the extremes of the value, and an add of a value already held.
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'h0000_0000, TYPED, 1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h8000_0000, TYPED, 1'b1, 7'd1},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h7FFF_FFFF, TYPED, 1'b1, 7'd2},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h0000_0000, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'hFFFF_FFFF, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h8000_0000, TYPED, 1'b1, 7'd4},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'h0000_3039, TYPED, 1'b0, 7'd4},
			// Removes of the first, the last and a middle entry.
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'h8000_0000, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'hFFFF_FFFF, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h5555_5555, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'hAAAA_AAAA, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'h0000_0000, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'h7FFF_FFFF, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'h5555_5555, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'hAAAA_AAAA, TYPED, 1'b1, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'hAAAA_AAAA, TYPED, 1'b0, 7'd0},
			// Capacity of one: a full set refuses even a value it already holds.
			'{ROW_CFG, 7'd1,   bst_pkg::ACT_ADD,    32'h0000_0000, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h0000_0005, TYPED, 1'b1, 7'd1},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h0000_0005, TYPED, 1'b0, 7'd1},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'h0000_0005, TYPED, 1'b1, 7'd0},
			// Capacity of zero: no add can succeed.
			'{ROW_CFG, 7'd0,   bst_pkg::ACT_ADD,    32'h0000_0000, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h0000_0009, TYPED, 1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_REMOVE, 32'h0000_0009, TYPED, 1'b0, 7'd0},
			// Capacity above the table depth.
			'{ROW_CFG, 7'd127, bst_pkg::ACT_ADD,    32'h0000_0000, PRED,  1'b0, 7'd0},
			'{ROW_OP,  7'd0,   bst_pkg::ACT_ADD,    32'h0000_0001, TYPED, 1'b1, 7'd1}
		};

		// The first phase fills the set; some later ones lower the capacity below the fill.
		cap_plan = '{127, 64, 3, 0, 100, 1, 65, 40, 64, 2, 0, 127};
		add_plan = '{80, 50, 35, 50, 60, 50, 85, 50, 70, 50, 55, 40};
		cap_plan[10] = $urandom_range(0, 127);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_capacity(directed_rows[i].cap);
			end else begin
				issue_op(directed_rows[i].act, directed_rows[i].val, directed_rows[i].mode,
					directed_rows[i].exp_ok, directed_rows[i].exp_size);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			write_capacity(bst_pkg::FILL_W'(cap_plan[p]));
			for (int n = 0; n < PHASE_OPS; n++) begin
				issue_op(($urandom_range(0, 99) < add_plan[p]) ? bst_pkg::ACT_ADD
					: bst_pkg::ACT_REMOVE, pick_value(), PRED, 1'b0, '0);
			end
		end

		// Drain: wait for the last results, then a spell longer than the slowest operation.
		start <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d predicted results never arrived",
				pending_results.size()));
		end

		$display("Run covered %0d operations and %0d results over %0d capacity settings.",
			ops_sent, results_seen, cap_writes);
		$display("Adds %0d ok / %0d refused, removes %0d ok / %0d refused, peak fill %0d.",
			adds_ok, adds_refused, removes_ok, removes_refused, max_fill);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: several times the slowest correct run.
	initial begin
		#25_000_000;
		$display("Watchdog expired with %0d results still pending.", pending_results.size());
		$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/bst_pkg.sv
rtl/bounded_set_table.sv
tb/tb_bounded_set_table.sv
